// ----- design/wde_pkg.sv -----
// shared types, constants and helpers of the winternitz digit encoder
`default_nettype none

package wde_pkg;

   localparam int DIGIT_WIDTH_RESET        = 4;
   localparam int DIGEST_BYTES_RESET       = 32;
   localparam int MAX_DIGEST_BYTES_DEFAULT = 64;
   localparam int QUEUE_DEPTH              = 2;

   typedef enum logic [0:0] {
      CSR_DIGIT_WIDTH  = 1'b0,
      CSR_DIGEST_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic {
      PH_MSG,
      PH_CHECK
   } phase_type;

   // one classified byte handed from the front to the back
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] wlog;
      logic       done;
      logic [3:0] l2;
   } job_type;

   typedef struct packed {
      logic [7:0] digit;
      logic [9:0] index;
      logic       is_checksum;
      logic       last;
   } result_type;

   // log2 of the digit width after clamping down to 1, 2, 4 or 8
   function automatic logic [1:0] eff_wlog(input logic [3:0] w);
      logic [1:0] r;
      if (w >= 4'd8) begin
         r = 2'd3;
      end else if (w >= 4'd4) begin
         r = 2'd2;
      end else if (w >= 4'd2) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

   function automatic logic [3:0] msb_pos(input logic [13:0] v);
      logic [3:0] p;
      p = 4'd0;
      for (int i = 0; i < 14; i++) begin
         if (v[i]) begin
            p = 4'(i);
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- design/winternitz_digit_encoder.sv -----
// winternitz base-2^w digit encoder with checksum, top level
// path: each byte goes through the job queue, cur_ff and the result queue
// throughput: one digit per cycle from the single back-end digit unit while the
//   result queue has room; a byte gives 8/w digits, l2 more if it ends a digest
// reset: registers return to width 4 and length 32, counters and queues clear
`default_nettype none

module winternitz_digit_encoder
   import wde_pkg::*;
#(
   parameter int MAX_DIGEST_BYTES = MAX_DIGEST_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input queue
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_digest_byte,
   // result queue
   output logic             empty,
   input  wire logic        pop,
   output logic      [7:0]  rsp_digit,
   output logic      [9:0]  rsp_digit_index,
   output logic             rsp_is_checksum,
   output logic             rsp_last,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   logic [3:0]    digit_width_ff, digit_width_in;
   logic [6:0]    digest_bytes_ff, digest_bytes_in;
   csr_index_type csr_sel;
   logic          csr_wr;

   logic          enq, q_full, q_empty, q_pop;
   job_type       job, q_job;
   logic          res_valid, out_full;
   result_type    res, out_res;

   assign pready  = 1'b1;
   assign csr_sel = csr_index_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      digit_width_in  = digit_width_ff;
      digest_bytes_in = digest_bytes_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            CSR_DIGIT_WIDTH:  digit_width_in  = pwdata[3:0];
            CSR_DIGEST_BYTES: digest_bytes_in = pwdata[6:0];
            default: begin
               digit_width_in = digit_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_DIGIT_WIDTH:  prdata = 32'(digit_width_ff);
         CSR_DIGEST_BYTES: prdata = 32'(digest_bytes_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_width_ff  <= 4'(DIGIT_WIDTH_RESET);
         digest_bytes_ff <= 7'(DIGEST_BYTES_RESET);
      end else begin
         digit_width_ff  <= digit_width_in;
         digest_bytes_ff <= digest_bytes_in;
      end
   end

   wde_front #(
      .MAX_DIGEST_BYTES(MAX_DIGEST_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .digit_width (digit_width_ff),
      .digest_bytes(digest_bytes_ff),
      .push        (push),
      .full        (q_full),
      .digest_byte (req_digest_byte),
      .enq         (enq),
      .job         (job)
   );

   wde_fifo #(
      .WIDTH($bits(job_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_job_q (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (enq),
      .wr_data(job),
      .rd_en  (q_pop),
      .rd_data(q_job),
      .full   (q_full),
      .empty  (q_empty)
   );

   wde_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_job    (q_job),
      .q_pop    (q_pop),
      .out_full (out_full),
      .res_valid(res_valid),
      .res      (res)
   );

   wde_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_out_q (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (res_valid),
      .wr_data(res),
      .rd_en  (pop),
      .rd_data(out_res),
      .full   (out_full),
      .empty  (empty)
   );

   assign full            = q_full;
   assign rsp_digit       = out_res.digit;
   assign rsp_digit_index = out_res.index;
   assign rsp_is_checksum = out_res.is_checksum;
   assign rsp_last        = out_res.last;

endmodule

`default_nettype wire

// ----- design/wde_fifo.sv -----
// small synchronous fifo of packed words
`default_nettype none

module wde_fifo
   import wde_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/wde_front.sv -----
// front end: accepts digest bytes, tracks the byte count, sizes the checksum
`default_nettype none

module wde_front
   import wde_pkg::*;
#(
   parameter int MAX_DIGEST_BYTES = MAX_DIGEST_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [3:0] digit_width,
   input  wire logic [6:0] digest_bytes,
   input  wire logic       push,
   input  wire logic       full,
   input  wire logic [7:0] digest_byte,
   output logic            enq,
   output job_type         job
);

   logic [6:0]  bytes_seen_ff, bytes_seen_in;
   logic [6:0]  bs_next;
   logic [6:0]  len;
   logic [1:0]  wlog;
   logic [3:0]  w;
   logic [9:0]  l1;
   logic [17:0] v_wide;
   logic [13:0] v;
   logic        done;

   always_comb begin
      if (digest_bytes == 7'd0) begin
         len = 7'd1;
      end else if (digest_bytes > 7'(MAX_DIGEST_BYTES)) begin
         len = 7'(MAX_DIGEST_BYTES);
      end else begin
         len = digest_bytes;
      end
   end

   assign wlog   = eff_wlog(digit_width);
   assign w      = 4'd1 << wlog;
   // l1 = len*8/w, v = l1*(2^w-1); l2 is the number of base-2^w digits of v
   assign l1     = 10'(len) << (2'd3 - wlog);
   assign v_wide = (18'(l1) << w) - 18'(l1);
   assign v      = v_wide[13:0];

   assign bs_next = bytes_seen_ff + 7'd1;
   assign done    = (bs_next >= len);
   assign enq     = push && !full;

   always_comb begin
      job.data = digest_byte;
      job.wlog = wlog;
      job.done = done;
      job.l2   = (msb_pos(v) >> wlog) + 4'd1;
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (enq) begin
         bytes_seen_in = done ? 7'd0 : bs_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/wde_back.sv -----
// back end: splits each byte into digits, keeps the checksum, emits checksum digits
`default_nettype none

module wde_back
   import wde_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_empty,
   input  wire job_type q_job,
   output logic      q_pop,
   input  wire logic out_full,
   output logic      res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [13:0] csum_ff, csum_in;
   logic [9:0]  index_ff, index_in;
   job_type     cur_ff, cur_in;

   logic        step, fin, load;
   logic [3:0]  w;
   logic [7:0]  lmax;
   logic [6:0]  shamt;
   logic [13:0] src;
   logic [13:0] shifted;
   logic [7:0]  digit;

   assign w       = 4'd1 << cur_ff.wlog;
   assign lmax    = 8'((9'd1 << w) - 9'd1);
   assign shamt   = 7'(cnt_ff) << cur_ff.wlog;
   assign src     = (phase_ff == PH_CHECK) ? csum_ff : 14'(cur_ff.data);
   assign shifted = src >> shamt;
   assign digit   = shifted[7:0] & lmax;

   assign step = busy_ff && !out_full;
   assign fin  = step && (cnt_ff == 4'd0) && ((phase_ff == PH_CHECK) || !cur_ff.done);
   assign load = !q_empty && (!busy_ff || fin);

   assign q_pop     = load;
   assign res_valid = step;

   always_comb begin
      res.digit       = digit;
      res.index       = index_ff;
      res.is_checksum = (phase_ff == PH_CHECK);
      res.last        = (phase_ff == PH_CHECK) && (cnt_ff == 4'd0);
   end

   always_comb begin
      phase_in = phase_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      csum_in  = csum_ff;
      index_in = index_ff;
      cur_in   = cur_ff;
      if (step) begin
         index_in = index_ff + 10'd1;
         unique case (phase_ff)
            PH_MSG: begin
               csum_in = csum_ff + 14'(lmax - digit);
               if (cnt_ff == 4'd0) begin
                  if (cur_ff.done) begin
                     phase_in = PH_CHECK;
                     cnt_in   = cur_ff.l2 - 4'd1;
                  end else begin
                     busy_in = 1'b0;
                  end
               end else begin
                  cnt_in = cnt_ff - 4'd1;
               end
            end
            PH_CHECK: begin
               if (cnt_ff == 4'd0) begin
                  // digest complete: start the next one from zero
                  busy_in  = 1'b0;
                  phase_in = PH_MSG;
                  csum_in  = '0;
                  index_in = '0;
               end else begin
                  cnt_in = cnt_ff - 4'd1;
               end
            end
            default: begin
               phase_in = PH_MSG;
            end
         endcase
      end
      if (load) begin
         busy_in  = 1'b1;
         phase_in = PH_MSG;
         cur_in   = q_job;
         cnt_in   = 4'd7 >> q_job.wlog;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MSG;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         csum_ff  <= '0;
         index_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         csum_ff  <= csum_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire
